// File: rtl/core/twcw_pkg.sv
`timescale 1ns / 1ps

package twcw_pkg;

  // Default geometry of the cell store.
  localparam int MaxColsDef = 128;
  localparam int MaxRowsDef = 64;

  // Fixed widths of the request, result and register fields.
  localparam int ReqTypeW = 2;
  localparam int CodeW    = 16;
  localparam int RdRowW   = 6;
  localparam int RdColW   = 7;
  localparam int WordW    = 32;
  localparam int OutRowW  = 6;
  localparam int OutColW  = 7;
  localparam int CfgColsW = 8;
  localparam int CfgRowsW = 7;
  localparam int AttrW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Character codes with a meaning of their own.
  localparam logic [CodeW-1:0] CodeCr = 16'h000D;
  localparam logic [CodeW-1:0] CodeLf = 16'h000A;

  // Register reset values.
  localparam logic [CfgColsW-1:0] ColsRst  = 8'd80;
  localparam logic [CfgRowsW-1:0] RowsRst  = 7'd25;
  localparam logic [AttrW-1:0]    AttrRst  = 16'd0;
  localparam logic [CodeW-1:0]    BlankRst = 16'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLS   = 3'd0,
    CFG_ROWS   = 3'd1,
    CFG_ATTR   = 3'd2,
    CFG_BLANK  = 3'd3,
    CFG_LOCKED = 3'd4
  } cfg_idx_e;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_WRITE = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_BLANK
  } state_e;

  typedef struct packed {
    logic [CfgColsW-1:0] cols;
    logic [CfgRowsW-1:0] rows;
    logic [AttrW-1:0]    attr;
    logic [CodeW-1:0]    blank;
    logic                locked;
  } cfg_t;

endpackage

// File: rtl/core/twcw_cell_ram.sv
`timescale 1ns / 1ps

module twcw_cell_ram #(
  parameter int AddrW = 13,
  parameter int DataW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/twcw_ctrl.sv
`timescale 1ns / 1ps

module twcw_ctrl import twcw_pkg::*; #(
  parameter int MaxCols = MaxColsDef,
  parameter int MaxRows = MaxRowsDef,
  localparam int ColW  = $clog2(MaxCols),
  localparam int RowW  = $clog2(MaxRows),
  localparam int AddrW = RowW + ColW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               start,
  output logic               busy,
  input  logic [ReqTypeW-1:0] req_type_i,
  input  logic [CodeW-1:0]   char_code_i,
  input  logic [RdRowW-1:0]  read_row_i,
  input  logic [RdColW-1:0]  read_col_i,
  output logic               done_o,
  output logic [WordW-1:0]   cell_word_o,
  output logic [OutRowW-1:0] cursor_row_out_o,
  output logic [OutColW-1:0] cursor_col_out_o,
  output logic               did_scroll_o,
  output logic               mem_en_o,
  output logic               mem_we_o,
  output logic [AddrW-1:0]   mem_addr_o,
  output logic [WordW-1:0]   mem_wdata_o,
  input  logic [WordW-1:0]   mem_rdata_i
);

  state_e state_q, state_d;

  logic [ReqTypeW-1:0] req_q;
  logic [CodeW-1:0]    code_q;
  logic [RdRowW-1:0]   rrow_q;
  logic [RdColW-1:0]   rcol_q;

  logic [RowW-1:0] top_q, top_d;
  logic [RowW-1:0] crow_q, crow_d;
  logic [ColW-1:0] ccol_q, ccol_d;
  logic [RowW-1:0] brow_q, brow_d;
  logic [ColW-1:0] bcol_q, bcol_d;
  logic            scr_q, scr_d;
  logic            done_q, done_d;
  logic [WordW-1:0] word_q, word_d;

  logic [RowW-1:0] rows_last, crow_sat, vis_row, phys_row;
  logic [ColW-1:0] cols_last, ccol_sat;
  logic [RowW:0]   phys_sum;
  logic            rd_in_range, at_last_row;

  // Effective window size, clamped to the store geometry.
  always_comb begin
    if (cfg_i.cols == '0) begin
      cols_last = '0;
    end else if ((CfgColsW+1)'(cfg_i.cols) >= (CfgColsW+1)'(MaxCols)) begin
      cols_last = ColW'(MaxCols - 1);
    end else begin
      cols_last = ColW'(cfg_i.cols - 1'b1);
    end
    if (cfg_i.rows == '0) begin
      rows_last = '0;
    end else if ((CfgRowsW+1)'(cfg_i.rows) >= (CfgRowsW+1)'(MaxRows)) begin
      rows_last = RowW'(MaxRows - 1);
    end else begin
      rows_last = RowW'(cfg_i.rows - 1'b1);
    end
  end

  assign crow_sat    = (crow_q > rows_last) ? rows_last : crow_q;
  assign ccol_sat    = (ccol_q > cols_last) ? cols_last : ccol_q;
  assign at_last_row = (crow_sat == rows_last);
  assign rd_in_range = (8'(rrow_q) <= 8'(rows_last)) && (9'(rcol_q) <= 9'(cols_last));

  // Visible row to physical row: the window starts at top_q and wraps.
  always_comb begin
    unique case (state_q)
      ST_BLANK: vis_row = brow_q;
      default: begin
        if (req_q == REQ_READ) begin
          vis_row = RowW'(rrow_q);
        end else begin
          vis_row = crow_sat;
        end
      end
    endcase
    phys_sum = (RowW+1)'(top_q) + (RowW+1)'(vis_row);
    if (phys_sum >= (RowW+1)'(MaxRows)) begin
      phys_row = RowW'(phys_sum - (RowW+1)'(MaxRows));
    end else begin
      phys_row = RowW'(phys_sum);
    end
  end

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    crow_d      = crow_q;
    ccol_d      = ccol_q;
    brow_d      = brow_q;
    bcol_d      = bcol_q;
    scr_d       = scr_q;
    done_d      = 1'b0;
    word_d      = '0;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = {phys_row, ccol_sat};
    mem_wdata_o = {cfg_i.attr, code_q};

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        scr_d   = 1'b0;
        unique case (req_q)
          REQ_WRITE: begin
            crow_d = crow_sat;
            ccol_d = ccol_sat;
            if (code_q == CodeCr) begin
              ccol_d = '0;
              if (!at_last_row) begin
                crow_d = crow_sat + 1'b1;
              end else if (!cfg_i.locked) begin
                scr_d = 1'b1;
              end
            end else if (code_q != CodeLf) begin
              mem_en_o = 1'b1;
              mem_we_o = 1'b1;
              if (ccol_sat != cols_last) begin
                ccol_d = ccol_sat + 1'b1;
              end else if (!at_last_row) begin
                crow_d = crow_sat + 1'b1;
                ccol_d = '0;
              end else if (!cfg_i.locked) begin
                ccol_d = '0;
                scr_d  = 1'b1;
              end
            end
            // A scroll moves the window base and then blanks the new bottom row.
            if (scr_d) begin
              top_d   = (top_q == RowW'(MaxRows - 1)) ? '0 : top_q + 1'b1;
              brow_d  = rows_last;
              bcol_d  = '0;
              done_d  = 1'b0;
              state_d = ST_BLANK;
            end
          end
          REQ_CLEAR: begin
            brow_d  = '0;
            bcol_d  = '0;
            done_d  = 1'b0;
            state_d = ST_BLANK;
          end
          REQ_READ: begin
            mem_addr_o = {phys_row, ColW'(rcol_q)};
            if (rd_in_range) begin
              mem_en_o = 1'b1;
              done_d   = 1'b0;
              state_d  = ST_READ;
            end
          end
          REQ_NONE: begin
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        word_d  = mem_rdata_i;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_BLANK: begin
        mem_en_o    = 1'b1;
        mem_we_o    = 1'b1;
        mem_addr_o  = {phys_row, bcol_q};
        mem_wdata_o = {cfg_i.attr, cfg_i.blank};
        if (bcol_q == cols_last) begin
          bcol_d = '0;
          if (brow_q == rows_last) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            brow_d = brow_q + 1'b1;
          end
        end else begin
          bcol_d = bcol_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      top_q   <= '0;
      crow_q  <= '0;
      ccol_q  <= '0;
      brow_q  <= '0;
      bcol_q  <= '0;
      scr_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      crow_q  <= crow_d;
      ccol_q  <= ccol_d;
      brow_q  <= brow_d;
      bcol_q  <= bcol_d;
      scr_q   <= scr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (state_q == ST_IDLE && start) begin
      req_q  <= req_type_i;
      code_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign cell_word_o      = word_q;
  assign cursor_row_out_o = OutRowW'(crow_q);
  assign cursor_col_out_o = OutColW'(ccol_q);
  assign did_scroll_o     = scr_q;

endmodule

// File: rtl/core/text_window_char_writer.sv
`timescale 1ns / 1ps
// A write, newline, ignored code, unused request or read outside the window is answered
// from the execute state once the request is taken; a read in the window also passes the read state;
// a scroll then blanks the new bottom row cell by cell; a clear blanks every visible cell in turn.
// Requests do not overlap: a request is taken, then carried out, and busy stays high until then.
// Reset clears the cursor, window base and registers; the cell store is not cleared.
// The receiver cannot stall: each result is shown for one cycle with done_o high.

module text_window_char_writer import twcw_pkg::*; #(
  parameter int MaxCols = MaxColsDef,
  parameter int MaxRows = MaxRowsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Request side.
  input  logic                start,
  output logic                busy,
  input  logic [ReqTypeW-1:0] req_type_i,
  input  logic [CodeW-1:0]    char_code_i,
  input  logic [RdRowW-1:0]   read_row_i,
  input  logic [RdColW-1:0]   read_col_i,
  // Result side.
  output logic                done_o,
  output logic [WordW-1:0]    cell_word_o,
  output logic [OutRowW-1:0]  cursor_row_out_o,
  output logic [OutColW-1:0]  cursor_col_out_o,
  output logic                did_scroll_o
);

  localparam int ColW  = $clog2(MaxCols);
  localparam int RowW  = $clog2(MaxRows);
  localparam int AddrW = RowW + ColW;

  cfg_t cfg_q;

  logic             mem_en;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_rdata;

  // Configuration registers. Writes must come only while the block is idle, which the
  // block itself does not enforce, so the controller can use them without a shadow copy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols   <= ColsRst;
      cfg_q.rows   <= RowsRst;
      cfg_q.attr   <= AttrRst;
      cfg_q.blank  <= BlankRst;
      cfg_q.locked <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLS:   cfg_q.cols   <= cfg_wdata_i[CfgColsW-1:0];
        CFG_ROWS:   cfg_q.rows   <= cfg_wdata_i[CfgRowsW-1:0];
        CFG_ATTR:   cfg_q.attr   <= cfg_wdata_i[AttrW-1:0];
        CFG_BLANK:  cfg_q.blank  <= cfg_wdata_i[CodeW-1:0];
        CFG_LOCKED: cfg_q.locked <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // The controller owns the cursor and the window base. Scrolling moves the
  // base row instead of copying rows, so only the new bottom row is rewritten.
  twcw_ctrl #(
    .MaxCols(MaxCols),
    .MaxRows(MaxRows)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .read_row_i      (read_row_i),
    .read_col_i      (read_col_i),
    .done_o          (done_o),
    .cell_word_o     (cell_word_o),
    .cursor_row_out_o(cursor_row_out_o),
    .cursor_col_out_o(cursor_col_out_o),
    .did_scroll_o    (did_scroll_o),
    .mem_en_o        (mem_en),
    .mem_we_o        (mem_we),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata)
  );

  // Cell store: physical row in the upper address bits, column in the lower.
  twcw_cell_ram #(
    .AddrW(AddrW),
    .DataW(WordW)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule
